// ----- hdl/vpiff_pkg.sv -----
// Shared types, widths and constants for the velocity PI controller with feedforward.
package vpiff_pkg;

  // Accumulator width (Q.8 signed), allowed range 32 to 64.
  localparam int ACC_W = 48;

  // Widths of the arithmetic path.
  localparam int FILT_W  = 40;  // filter value, signed Q23.16
  localparam int SUM_FW  = 41;  // filter value plus shifted last reference
  localparam int ERR_W   = 18;  // controller error
  localparam int DELTA_W = 43;  // g0*e - g1*e_prev
  localparam int SUM_W   = ((ACC_W > DELTA_W) ? ACC_W : DELTA_W) + 1;
  localparam int MUL_W   = 25;  // shared multiplier operand width (signed)
  localparam int PROD_W  = 2 * MUL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COEFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_G0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_G1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DLIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIM  = 3'd4;

  localparam logic [15:0] COEFF_RST = 16'd33698;
  localparam logic [23:0] G0_RST    = 24'd158566;
  localparam logic [23:0] G1_RST    = 24'd81535;
  localparam logic [9:0]  DLIM_RST  = 10'd1023;
  localparam logic [7:0]  FLIM_RST  = 8'd9;

  typedef struct packed {
    logic [15:0] coeff;
    logic [23:0] g0;
    logic [23:0] g1;
    logic [9:0]  dlim;
    logic [7:0]  flim;
  } cfg_t;

  typedef struct packed {
    logic                     en;
    logic signed [MUL_W-1:0]  a;
    logic signed [MUL_W-1:0]  b;
  } mul_req_t;

endpackage

// ----- hdl/vpiff_if.sv -----
// Channel interfaces: input samples and output results.
interface vpiff_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] reference;
  logic signed [15:0] measured_speed;

  modport source (output valid, reference, measured_speed, input ready);
  modport sink   (input valid, reference, measured_speed, output ready);
endinterface

interface vpiff_result_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] drive;
  logic signed [8:0]  feedforward_out;
  logic               drive_clamped;

  modport source (output valid, drive, feedforward_out, drive_clamped, input ready);
  modport sink   (input valid, drive, feedforward_out, drive_clamped, output ready);
endinterface

// ----- hdl/vpiff_cfg.sv -----
// Configuration register file with reset defaults.
module vpiff_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [vpiff_pkg::CFG_IDX_W-1:0]   index,
  input  logic [vpiff_pkg::CFG_DATA_W-1:0]  data,
  output vpiff_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coeff <= vpiff_pkg::COEFF_RST;
      cfg.g0    <= vpiff_pkg::G0_RST;
      cfg.g1    <= vpiff_pkg::G1_RST;
      cfg.dlim  <= vpiff_pkg::DLIM_RST;
      cfg.flim  <= vpiff_pkg::FLIM_RST;
    end else if (we) begin
      case (index)
        vpiff_pkg::REG_COEFF: cfg.coeff <= data[15:0];
        vpiff_pkg::REG_G0:    cfg.g0    <= data[23:0];
        vpiff_pkg::REG_G1:    cfg.g1    <= data[23:0];
        vpiff_pkg::REG_DLIM:  cfg.dlim  <= data[9:0];
        vpiff_pkg::REG_FLIM:  cfg.flim  <= data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/vpiff_mul.sv -----
// Shared signed multiplier with registered product.
module vpiff_mul (
  input  logic                                   clk,
  input  vpiff_pkg::mul_req_t                    req,
  output logic signed [vpiff_pkg::PROD_W-1:0]    p
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      p <= req.a * req.b;
    end
  end

endmodule

// ----- hdl/velocity_pi_with_feedforward.sv -----
// Top level: sequencer and datapath of the velocity PI controller with feedforward.
//
//   channel   dir  handshake        payload
//   samples   in   valid / ready    reference[16s], measured_speed[16s]
//   results   out  valid / ready    drive[11s], feedforward_out[9s], drive_clamped[1]
//   cfg       in   cfg_we           cfg_index[3], cfg_data[24]
//
// Each sample takes the accept cycle plus ten sequencer steps that
// share one 25x25 signed multiplier (two partial products for the filter,
// one each for the two gains). The result register loads in the last step
// (ST_DRV), and samples.ready rises at that same edge, so a new sample is
// accepted only after the previous one has left the sequencer.
// Reset (rst, synchronous) restores register defaults and clears filter,
// last reference, last error and accumulator.
// A result waiting on results.ready holds the sequencer in its last step;
// samples.ready stays low until the result is taken.
module velocity_pi_with_feedforward (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vpiff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpiff_pkg::CFG_DATA_W-1:0]     cfg_data,
  vpiff_sample_if.sink                         samples,
  vpiff_result_if.source                       results
);

  // Sequencer steps.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FF_LO  = 4'd1;   // coeff * low part of sum
  localparam logic [3:0] ST_FF_HI  = 4'd2;   // coeff * high part of sum
  localparam logic [3:0] ST_FF_SUM = 4'd3;   // combine, shift, saturate filter
  localparam logic [3:0] ST_FF_OUT = 4'd4;   // clamp and round feedforward
  localparam logic [3:0] ST_ERR    = 4'd5;   // error = ff - measured
  localparam logic [3:0] ST_G0     = 4'd6;   // g0 * e
  localparam logic [3:0] ST_G1     = 4'd7;   // g1 * e_prev
  localparam logic [3:0] ST_DELTA  = 4'd8;   // difference of the two products
  localparam logic [3:0] ST_ACC    = 4'd9;   // saturating accumulate
  localparam logic [3:0] ST_DRV    = 4'd10;  // clamp, round, load result

  localparam int AW = vpiff_pkg::ACC_W;
  localparam int SW = vpiff_pkg::SUM_W;
  localparam int DW = vpiff_pkg::DELTA_W;
  localparam int PW = vpiff_pkg::PROD_W;

  vpiff_pkg::cfg_t     cfg;
  vpiff_pkg::mul_req_t mreq;
  logic signed [PW-1:0] mul_p;

  logic [3:0] state;
  logic [3:0] state_next;

  // Architectural state.
  logic signed [vpiff_pkg::FILT_W-1:0] filter_value;
  logic signed [15:0]                  last_reference;
  logic signed [vpiff_pkg::ERR_W-1:0]  last_error;
  logic signed [AW-1:0]                accumulator;

  // Working registers of one sample.
  logic signed [vpiff_pkg::SUM_FW-1:0] sum_r;
  logic signed [15:0]                  meas_r;
  logic signed [PW-1:0]                tmp;
  logic signed [8:0]                   ff_r;
  logic signed [vpiff_pkg::ERR_W-1:0]  e_r;
  logic signed [DW-1:0]                delta_r;

  logic accept;
  logic res_free;

  vpiff_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  vpiff_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p   (mul_p)
  );

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign res_free      = !results.valid || results.ready;

  // Multiplier operand selection.
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = '0;
    mreq.b  = '0;
    case (state)
      ST_FF_LO: begin
        mreq.en = 1'b1;
        mreq.a  = {9'b0, cfg.coeff};
        mreq.b  = {1'b0, sum_r[23:0]};
      end
      ST_FF_HI: begin
        mreq.en = 1'b1;
        mreq.a  = {9'b0, cfg.coeff};
        mreq.b  = {{8{sum_r[40]}}, sum_r[40:24]};
      end
      ST_G0: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, cfg.g0};
        mreq.b  = {{7{e_r[17]}}, e_r};
      end
      ST_G1: begin
        mreq.en = 1'b1;
        mreq.a  = {1'b0, cfg.g1};
        mreq.b  = {{7{last_error[17]}}, last_error};
      end
      default: ;
    endcase
  end

  // Filter: full product = hi * 2^24 + lo, then floor shift by 16 and saturate.
  logic [56:0]         ff_prod;
  logic signed [40:0]  ff_shift;
  logic signed [39:0]  ff_sat;

  always_comb begin
    ff_prod  = {mul_p[32:0], 24'b0} + {17'b0, tmp[39:0]};
    ff_shift = signed'(ff_prod[56:16]);
    if (ff_shift[40] != ff_shift[39]) begin
      ff_sat = ff_shift[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end else begin
      ff_sat = ff_shift[39:0];
    end
  end

  // Feedforward clamp to +-flim (Q16), add one half, truncate toward zero.
  logic [23:0]         fhi;
  logic signed [39:0]  fhi_w;
  logic signed [25:0]  fclamp;
  logic signed [25:0]  fy;
  logic [9:0]          fq;

  always_comb begin
    fhi   = {cfg.flim, 16'b0};
    fhi_w = signed'({16'b0, fhi});
    if (filter_value > fhi_w) begin
      fclamp = signed'({2'b0, fhi});
    end else if (filter_value < -fhi_w) begin
      fclamp = -signed'({2'b0, fhi});
    end else begin
      fclamp = filter_value[25:0];
    end
    fy = fclamp + 26'sd32768;
    fq = fy[25:16] + {9'b0, (fy[25] && (fy[15:0] != 16'b0))};
  end

  // Saturating accumulate in a width that holds both operands.
  logic signed [SW-1:0] acc_sum;
  logic signed [AW-1:0] acc_sat;

  always_comb begin
    acc_sum = signed'({{(SW-AW){accumulator[AW-1]}}, accumulator})
            + signed'({{(SW-DW){delta_r[DW-1]}}, delta_r});
    if (acc_sum[SW-1:AW-1] != {(SW-AW+1){1'b0}} &&
        acc_sum[SW-1:AW-1] != {(SW-AW+1){1'b1}}) begin
      acc_sat = acc_sum[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AW-1:0];
    end
  end

  // Drive clamp to +-dlim (Q8), add one half, truncate toward zero.
  logic [17:0]         dhi;
  logic signed [AW-1:0] dhi_w;
  logic signed [19:0]  dclamp;
  logic signed [19:0]  dy;
  logic [11:0]         dq;
  logic                dhit;

  always_comb begin
    dhi   = {cfg.dlim, 8'b0};
    dhi_w = signed'({{(AW-18){1'b0}}, dhi});
    dhit  = 1'b1;
    if (accumulator > dhi_w) begin
      dclamp = signed'({2'b0, dhi});
    end else if (accumulator < -dhi_w) begin
      dclamp = -signed'({2'b0, dhi});
    end else begin
      dclamp = accumulator[19:0];
      dhit   = 1'b0;
    end
    dy = dclamp + 20'sd128;
    dq = dy[19:8] + {11'b0, (dy[19] && (dy[7:0] != 8'b0))};
  end

  // Step order; hold the last step while the result register is full and not being taken.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_FF_LO;
      ST_FF_LO:  state_next = ST_FF_HI;
      ST_FF_HI:  state_next = ST_FF_SUM;
      ST_FF_SUM: state_next = ST_FF_OUT;
      ST_FF_OUT: state_next = ST_ERR;
      ST_ERR:    state_next = ST_G0;
      ST_G0:     state_next = ST_G1;
      ST_G1:     state_next = ST_DELTA;
      ST_DELTA:  state_next = ST_ACC;
      ST_ACC:    state_next = ST_DRV;
      ST_DRV:    if (res_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      filter_value   <= '0;
      last_reference <= '0;
      last_error     <= '0;
      accumulator    <= '0;
      results.valid  <= 1'b0;
    end else begin
      state <= state_next;
      // Raise valid when the last step loads a result; drop it once the transaction is taken.
      if (state == ST_DRV && res_free) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE:   if (accept) last_reference <= samples.reference;
        ST_FF_SUM: filter_value <= ff_sat;
        ST_G1:     last_error <= e_r;
        ST_ACC:    accumulator <= acc_sat;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          // Sum uses the filter and reference left by the previous sample.
          sum_r  <= signed'({filter_value[39], filter_value})
                  + signed'({{9{last_reference[15]}}, last_reference, 16'b0});
          meas_r <= samples.measured_speed;
        end
      end
      ST_FF_HI:  tmp <= mul_p;
      ST_FF_OUT: ff_r <= fq[8:0];
      ST_ERR:    e_r <= signed'({{9{ff_r[8]}}, ff_r}) - signed'({{2{meas_r[15]}}, meas_r});
      ST_G1:     tmp <= mul_p;
      ST_DELTA:  delta_r <= tmp[DW-1:0] - mul_p[DW-1:0];
      ST_DRV: begin
        if (res_free) begin
          results.drive           <= dq[10:0];
          results.feedforward_out <= ff_r;
          results.drive_clamped   <= dhit;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_FF_LO)
    else $error("accepted sample did not start the sequence");

  a_drv_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRV && results.valid && !results.ready) |=> state == ST_DRV)
    else $error("sequencer left last step while result register was full");

  a_ff_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ERR |->
      signed'({ff_r[8], ff_r}) <= signed'({2'b0, cfg.flim}) &&
      signed'({ff_r[8], ff_r}) >= -signed'({2'b0, cfg.flim}))
    else $error("feedforward value outside its limit");

  a_mul_only_in_steps: assert property (@(posedge clk) disable iff (rst)
    mreq.en |-> state != ST_IDLE && state != ST_DRV)
    else $error("multiplier enabled outside an arithmetic step");
`endif

endmodule
